// ----- design/modular_exponentiation_assert.svh -----
// assertion macros for the modular exponentiation core
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MODEXP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MODEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/modexp_pkg.sv -----
// microcode format, step addresses and program rom of the modular exponentiation core
package modexp_pkg;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // what a step waits for before it completes
  typedef logic [1:0] wait_t;
  localparam wait_t WAIT_NONE = 2'd0;
  localparam wait_t WAIT_IN   = 2'd1;
  localparam wait_t WAIT_MUL  = 2'd2;
  localparam wait_t WAIT_OUT  = 2'd3;

  // branch condition evaluated when a step completes
  typedef logic [1:0] jump_t;
  localparam jump_t JMP_NEVER  = 2'd0;
  localparam jump_t JMP_ALWAYS = 2'd1;
  localparam jump_t JMP_EBIT0  = 2'd2;
  localparam jump_t JMP_MORE   = 2'd3;

  // multiplier operand selection
  typedef logic [1:0] opsel_t;
  localparam opsel_t OPS_RED = 2'd0;
  localparam opsel_t OPS_SQR = 2'd1;
  localparam opsel_t OPS_MUL = 2'd2;

  // product destination
  typedef logic [1:0] dst_t;
  localparam dst_t DST_NONE = 2'd0;
  localparam dst_t DST_BASE = 2'd1;
  localparam dst_t DST_ACC  = 2'd2;

  // step addresses
  localparam pc_t PC_IDLE   = 4'd0;
  localparam pc_t PC_RED_GO = 4'd1;
  localparam pc_t PC_RED_WT = 4'd2;
  localparam pc_t PC_INIT   = 4'd3;
  localparam pc_t PC_SQR_GO = 4'd4;
  localparam pc_t PC_SQR_WT = 4'd5;
  localparam pc_t PC_MUL_GO = 4'd6;
  localparam pc_t PC_MUL_WT = 4'd7;
  localparam pc_t PC_NEXT   = 4'd8;
  localparam pc_t PC_OUT    = 4'd9;

  typedef struct packed {
    wait_t  wait_on;
    jump_t  jump;
    pc_t    target;
    logic   mul_go;
    opsel_t opsel;
    dst_t   dst;
    logic   load_in;
    logic   init_acc;
    logic   exp_shift;
    logic   load_out;
  } uword_t;

  // strobes from the sequencer to the datapath
  typedef struct packed {
    logic   in_open;
    logic   load_in;
    logic   mul_go;
    opsel_t opsel;
    dst_t   dst;
    logic   init_acc;
    logic   exp_shift;
    logic   load_out;
  } ctrl_t;

  // conditions from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic mul_busy;
    logic ebit;
    logic cnt_zero;
    logic out_ready;
  } status_t;

  localparam uword_t UW_NOP = '{
    wait_on:   WAIT_NONE,
    jump:      JMP_NEVER,
    target:    PC_IDLE,
    mul_go:    1'b0,
    opsel:     OPS_RED,
    dst:       DST_NONE,
    load_in:   1'b0,
    init_acc:  1'b0,
    exp_shift: 1'b0,
    load_out:  1'b0
  };

  // left-to-right square and multiply program
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t uw;
    uw = UW_NOP;
    case (pc)
      PC_IDLE: begin
        uw.wait_on = WAIT_IN;
        uw.load_in = 1'b1;
      end
      PC_RED_GO: begin
        uw.mul_go = 1'b1;
        uw.opsel  = OPS_RED;
      end
      PC_RED_WT: begin
        uw.wait_on = WAIT_MUL;
        uw.dst     = DST_BASE;
      end
      PC_INIT: begin
        uw.init_acc = 1'b1;
      end
      PC_SQR_GO: begin
        uw.mul_go = 1'b1;
        uw.opsel  = OPS_SQR;
      end
      PC_SQR_WT: begin
        uw.wait_on = WAIT_MUL;
        uw.dst     = DST_ACC;
        uw.jump    = JMP_EBIT0;
        uw.target  = PC_NEXT;
      end
      PC_MUL_GO: begin
        uw.mul_go = 1'b1;
        uw.opsel  = OPS_MUL;
      end
      PC_MUL_WT: begin
        uw.wait_on = WAIT_MUL;
        uw.dst     = DST_ACC;
      end
      PC_NEXT: begin
        uw.exp_shift = 1'b1;
        uw.jump      = JMP_MORE;
        uw.target    = PC_SQR_GO;
      end
      PC_OUT: begin
        uw.wait_on  = WAIT_OUT;
        uw.load_out = 1'b1;
        uw.jump     = JMP_ALWAYS;
        uw.target   = PC_IDLE;
      end
      default: begin
        uw.jump   = JMP_ALWAYS;
        uw.target = PC_IDLE;
      end
    endcase
    return uw;
  endfunction

endpackage

// ----- design/modular_exponentiation.sv -----
// top level of the modular exponentiation core: registers, datapath and output stage
//
// Computes residue = message ^ key_exponent mod key_modulus for each input
// transaction, with the message first reduced modulo key_modulus.
// Input channel: in_valid / in_stall with message; a transaction is taken when
// in_valid is high and in_stall is low. Output channel: out_valid / out_stall
// with residue, one result transaction for each input transaction.
// Configuration: key_exponent at address 0, key_modulus at 4 (8 when
// OPERAND_WIDTH exceeds 32); write only while no transaction is in flight.
// A modulus of 0 yields a residue of 0.
// Each exponent bit costs a square and, when the bit is set, a multiply in the
// one-bit-per-cycle modular multiplier, plus one step. One item is worked on
// at a time. Reset loads exponent 1 and modulus 1 and empties the output
// register. A stalled result stays in the output register; the next item is
// still accepted and computed, and waits to be written until the register
// is free.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [((OPERAND_WIDTH > 32) ? 4 : 3)-1:0]    paddr,
  input  logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0]  pwdata,
  output logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0]  prdata,
  output logic                                         pready,
  input  logic                                         in_valid,
  output logic                                         in_stall,
  input  logic [OPERAND_WIDTH-1:0]                     message,
  output logic                                         out_valid,
  input  logic                                         out_stall,
  output logic [OPERAND_WIDTH-1:0]                     residue
);

  localparam int W      = OPERAND_WIDTH;
  localparam int DATA_W = (W > 32) ? 64 : 32;
  localparam int ADDR_W = (W > 32) ? 4 : 3;
  localparam int CNT_W  = $clog2(W);

  logic [W-1:0]        key_exponent;
  logic [W-1:0]        key_modulus;
  logic [W-1:0]        msg;
  logic [W-1:0]        exp_sh;
  logic [W-1:0]        base;
  logic [W-1:0]        acc;
  logic [CNT_W-1:0]    cnt;
  logic [W-1:0]        mul_a;
  logic [W-1:0]        mul_b;
  logic [W-1:0]        product;
  logic                mul_busy;
  logic                reg_sel;
  modexp_pkg::ctrl_t   ctrl;
  modexp_pkg::status_t status;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1];
  assign prdata  = reg_sel ? DATA_W'(key_modulus) : DATA_W'(key_exponent);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_exponent <= W'(1);
      key_modulus  <= W'(1);
    end else if (psel && penable && pwrite && pready) begin
      if (reg_sel) begin
        key_modulus <= pwdata[W-1:0];
      end else begin
        key_exponent <= pwdata[W-1:0];
      end
    end
  end

  // sequencer
  assign status.in_valid  = in_valid;
  assign status.mul_busy  = mul_busy;
  assign status.ebit      = exp_sh[W-1];
  assign status.cnt_zero  = (cnt == '0);
  assign status.out_ready = !out_valid || !out_stall;

  modexp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign in_stall = !ctrl.in_open;

  // multiplier operands: reduction is 1 times message, then square or multiply
  always_comb begin
    case (ctrl.opsel)
      modexp_pkg::OPS_RED: begin
        mul_a = W'(1);
        mul_b = msg;
      end
      modexp_pkg::OPS_MUL: begin
        mul_a = acc;
        mul_b = base;
      end
      default: begin
        mul_a = acc;
        mul_b = acc;
      end
    endcase
  end

  modexp_mulu #(
    .OPERAND_WIDTH (W)
  ) u_mulu (
    .clk     (clk),
    .rst     (rst),
    .start   (ctrl.mul_go),
    .a       (mul_a),
    .b       (mul_b),
    .m       (key_modulus),
    .busy    (mul_busy),
    .product (product)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      msg    <= message;
      exp_sh <= key_exponent;
    end
    if (ctrl.dst == modexp_pkg::DST_BASE) begin
      base <= product;
    end
    if (ctrl.dst == modexp_pkg::DST_ACC) begin
      acc <= product;
    end
    if (ctrl.init_acc) begin
      acc <= (key_modulus == W'(1)) ? '0 : W'(1);
      cnt <= CNT_W'(W - 1);
    end
    if (ctrl.exp_shift) begin
      exp_sh <= exp_sh << 1;
      cnt    <= cnt - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      residue <= (key_modulus == '0) ? '0 : acc;
    end
  end

  // checks
  `MODEXP_ASSERT_NOW(a_accept_quiet, in_valid && !in_stall, !mul_busy, "input taken while multiplier busy")
  `MODEXP_ASSERT_NOW(a_start_quiet, ctrl.mul_go, !mul_busy, "multiplier restarted while busy")
  `MODEXP_ASSERT_NOW(a_out_free, ctrl.load_out, !out_valid || !out_stall, "output register overwritten while stalled")
  `MODEXP_ASSERT_NEXT(a_out_set, ctrl.load_out, out_valid, "result written but not presented")

endmodule

// ----- design/modexp_mulu.sv -----
// interleaved shift-and-add modular multiplier, one multiplier bit per cycle
module modexp_mulu #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output logic                     busy,
  output logic [OPERAND_WIDTH-1:0] product
);

  localparam int W     = OPERAND_WIDTH;
  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     acc;
  logic [W-1:0]     a_q;
  logic [W-1:0]     b_sh;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     dbl;
  logic [W-1:0]     acc_next;

  // (x + y) mod mm for x, y below mm, without overflow
  function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                           input logic [W-1:0] mm);
    logic [W-1:0] gap;
    gap = mm - y;
    if (x >= gap) return x - gap;
    return x + y;
  endfunction

  // double, then add a when the current multiplier bit is set
  always_comb begin
    dbl      = mod_add(acc, acc, m);
    acc_next = b_sh[W-1] ? mod_add(dbl, a_q, m) : dbl;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_q  <= a;
      b_sh <= b;
      cnt  <= CNT_W'(W - 1);
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= b_sh << 1;
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign product = acc;

endmodule

// ----- design/modexp_seq.sv -----
// microcode sequencer: step counter, program rom and branch logic
module modexp_seq (
  input  logic                clk,
  input  logic                rst,
  input  modexp_pkg::status_t status,
  output modexp_pkg::ctrl_t   ctrl
);

  modexp_pkg::pc_t    pc;
  modexp_pkg::pc_t    pc_next;
  modexp_pkg::uword_t uw;
  logic               step_done;

  assign uw = modexp_pkg::ucode_rom(pc);

  // wait condition of the current step
  always_comb begin
    unique case (uw.wait_on)
      modexp_pkg::WAIT_NONE: step_done = 1'b1;
      modexp_pkg::WAIT_IN:   step_done = status.in_valid;
      modexp_pkg::WAIT_MUL:  step_done = !status.mul_busy;
      modexp_pkg::WAIT_OUT:  step_done = status.out_ready;
      default:               step_done = 1'b0;
    endcase
  end

  // branch
  always_comb begin
    pc_next = pc;
    if (step_done) begin
      unique case (uw.jump)
        modexp_pkg::JMP_NEVER:  pc_next = pc + modexp_pkg::pc_t'(1);
        modexp_pkg::JMP_ALWAYS: pc_next = uw.target;
        modexp_pkg::JMP_EBIT0:  pc_next = status.ebit ? pc + modexp_pkg::pc_t'(1) : uw.target;
        modexp_pkg::JMP_MORE:   pc_next = status.cnt_zero ? pc + modexp_pkg::pc_t'(1) : uw.target;
        default:                pc_next = modexp_pkg::PC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= modexp_pkg::PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // strobes fire only when the step completes; in_open is high throughout the input wait step
  always_comb begin
    ctrl.in_open   = (uw.wait_on == modexp_pkg::WAIT_IN);
    ctrl.load_in   = uw.load_in && step_done;
    ctrl.mul_go    = uw.mul_go && step_done;
    ctrl.opsel     = uw.opsel;
    ctrl.dst       = step_done ? uw.dst : modexp_pkg::DST_NONE;
    ctrl.init_acc  = uw.init_acc && step_done;
    ctrl.exp_shift = uw.exp_shift && step_done;
    ctrl.load_out  = uw.load_out && step_done;
  end

endmodule
